// ===== hw/rtl/vcu_pkg.sv =====
package vcu_pkg;

  localparam int IDX_FIELD_W  = 6;
  localparam int PEER_W       = 6;
  localparam int VALUE_W      = 32;
  localparam int PCOUNT_W     = 7;
  localparam int MODE_W       = 2;
  localparam int TDATA_W      = 48;
  localparam int PADDR_W      = 3;
  localparam int PDATA_W      = 32;

  // Register numbers, taken from paddr[2].
  localparam logic REG_OWN   = 1'b0;
  localparam logic REG_COUNT = 1'b1;

  localparam logic [IDX_FIELD_W-1:0] OWN_RESET   = '0;
  localparam logic [PCOUNT_W-1:0]    COUNT_RESET = 7'd16;

  typedef enum logic [MODE_W-1:0] {
    MODE_EXEC = 2'd0,
    MODE_SEND = 2'd1,
    MODE_RECV = 2'd2
  } mode_t;

  typedef enum logic {
    ST_IDLE,
    ST_EMIT
  } state_t;

  // Command broadcast to every cell of the chain.
  typedef struct packed {
    logic                   rotate;
    logic                   merge;
    logic                   bump;
    logic [IDX_FIELD_W-1:0] elem_index;
    logic [IDX_FIELD_W-1:0] own_index;
  } cell_cmd_t;

endpackage

// ===== hw/rtl/vcu_cell.sv =====
module vcu_cell #(
  parameter int COUNT_WIDTH = 32,
  parameter int INDEX       = 0
) (
  input  logic                   clk,
  input  logic                   rst,
  input  vcu_pkg::cell_cmd_t     cmd,
  input  logic [COUNT_WIDTH-1:0] elem_value,
  input  logic [COUNT_WIDTH-1:0] nbr_count,
  output logic [COUNT_WIDTH-1:0] count
);
  import vcu_pkg::*;

  localparam logic [IDX_FIELD_W-1:0] MY_INDEX = IDX_FIELD_W'(INDEX);

  logic [COUNT_WIDTH-1:0] merged;
  logic [COUNT_WIDTH-1:0] bumped;
  logic [COUNT_WIDTH-1:0] count_next;

  always_comb begin
    merged = count;
    if (cmd.merge && cmd.elem_index == MY_INDEX && elem_value > count) begin
      merged = elem_value;
    end
    bumped = merged;
    // The increment saturates at the all-ones value.
    if (cmd.bump && cmd.own_index == MY_INDEX && merged != '1) begin
      bumped = merged + COUNT_WIDTH'(1);
    end
    count_next = cmd.rotate ? nbr_count : bumped;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

endmodule

// ===== hw/rtl/vector_clock_unit.sv =====
// Channel   Direction  Beat contents
// s_*       in         tuser mode, tdata {elem_value, elem_index, peer}, tlast elem_last
// m_*       out        tuser event_kind, tdata {entry_value, entry_index, peer_out},
//                      tlast last_entry
// APB       in/out     own_index at 0x0, process_count at 0x4
//
// A receive element that is not last is merged as it is accepted. A completed event
// rotates the ring of MAX_PROCS cells once, one step per cycle unless output
// back-pressure holds it, and streams entries from cell 0; the input is held until the
// rotation ends. Reset clears every counter and restores the register defaults.
// Back-pressure on the output halts the rotation while entries are still due.
module vector_clock_unit #(
  parameter int MAX_PROCS   = 16,
  parameter int COUNT_WIDTH = 32
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // [5:0] peer, [11:6] elem_index, [43:12] elem_value, [47:44] zero
  input  logic [vcu_pkg::TDATA_W-1:0]     s_tdata,
  // [1:0] mode
  input  logic [vcu_pkg::MODE_W-1:0]      s_tuser,
  input  logic                            s_tlast,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // [5:0] peer_out, [11:6] entry_index, [43:12] entry_value, [47:44] zero
  output logic [vcu_pkg::TDATA_W-1:0]     m_tdata,
  // [1:0] event_kind
  output logic [vcu_pkg::MODE_W-1:0]      m_tuser,
  output logic                            m_tlast,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [vcu_pkg::PADDR_W-1:0]     paddr,
  input  logic [vcu_pkg::PDATA_W-1:0]     pwdata,
  output logic [vcu_pkg::PDATA_W-1:0]     prdata,
  output logic                            pready
);
  import vcu_pkg::*;

  localparam int CNT_W = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;

  // Configuration registers.
  logic [IDX_FIELD_W-1:0] own_index;
  logic [PCOUNT_W-1:0]    process_count;
  logic                   reg_sel;
  logic                   cfg_wr;

  assign pready  = 1'b1;
  assign reg_sel = paddr[2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      own_index     <= OWN_RESET;
      process_count <= COUNT_RESET;
    end else if (cfg_wr) begin
      case (reg_sel)
        REG_OWN:   own_index     <= pwdata[IDX_FIELD_W-1:0];
        REG_COUNT: process_count <= pwdata[PCOUNT_W-1:0];
        default:   ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_OWN:   prdata = PDATA_W'(own_index);
      REG_COUNT: prdata = PDATA_W'(process_count);
      default:   prdata = '0;
    endcase
  end

  // Entries in use, clamped to 1..MAX_PROCS.
  logic [PCOUNT_W-1:0] n_used;
  always_comb begin
    if (process_count == '0) begin
      n_used = PCOUNT_W'(1);
    end else if (process_count > PCOUNT_W'(MAX_PROCS)) begin
      n_used = PCOUNT_W'(MAX_PROCS);
    end else begin
      n_used = process_count;
    end
  end

  // Input fields.
  logic [PEER_W-1:0]      in_peer;
  logic [IDX_FIELD_W-1:0] in_index;
  logic [VALUE_W-1:0]     in_value;
  mode_t                  in_mode;

  assign in_peer  = s_tdata[PEER_W-1:0];
  assign in_index = s_tdata[PEER_W+IDX_FIELD_W-1:PEER_W];
  assign in_value = s_tdata[PEER_W+IDX_FIELD_W+VALUE_W-1:PEER_W+IDX_FIELD_W];
  assign in_mode  = mode_t'(s_tuser);

  // Incoming value brought to the counter width; values beyond it saturate.
  logic [COUNT_WIDTH-1:0] val_ext;
  generate
    if (COUNT_WIDTH >= VALUE_W) begin : g_val_wide
      assign val_ext = COUNT_WIDTH'(in_value);
    end else begin : g_val_narrow
      localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;
      assign val_ext = (in_value > VALUE_W'(CNT_MAX)) ? CNT_MAX
                                                       : in_value[COUNT_WIDTH-1:0];
    end
  endgenerate

  // Control.
  state_t           state;
  state_t           state_next;
  logic [CNT_W-1:0] rot_cnt;
  logic             accept;
  logic             completes;
  logic             step;
  logic             load;
  logic             rot_done;
  logic [MODE_W-1:0] kind;
  logic [PEER_W-1:0] kind_peer;
  cell_cmd_t        cmd;

  assign accept   = s_tvalid && s_tready;
  assign rot_done = rot_cnt == CNT_W'(MAX_PROCS - 1);
  assign load     = step && (PCOUNT_W'(rot_cnt) < n_used);

  always_comb begin
    state_next     = state;
    s_tready       = 1'b0;
    step           = 1'b0;
    completes      = 1'b0;
    cmd.rotate     = 1'b0;
    cmd.merge      = 1'b0;
    cmd.bump       = 1'b0;
    cmd.elem_index = in_index;
    cmd.own_index  = own_index;
    case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          case (in_mode)
            MODE_EXEC, MODE_SEND: begin
              completes = 1'b1;
            end
            MODE_RECV: begin
              cmd.merge = PCOUNT_W'(in_index) < n_used;
              completes = s_tlast;
            end
            default: ;
          endcase
          cmd.bump = completes && (PCOUNT_W'(own_index) < n_used);
          if (completes) begin
            state_next = ST_EMIT;
          end
        end
      end
      ST_EMIT: begin
        // Entries past the used count rotate through without a beat.
        step       = (PCOUNT_W'(rot_cnt) >= n_used) || !m_tvalid || m_tready;
        cmd.rotate = step;
        if (step && rot_done) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      rot_cnt <= '0;
    end else begin
      state <= state_next;
      if (step) begin
        rot_cnt <= rot_done ? '0 : rot_cnt + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && completes) begin
      kind      <= s_tuser;
      kind_peer <= (in_mode == MODE_EXEC) ? '0 : in_peer;
    end
  end

  // Ring of cells; cell k takes its neighbour k+1 on every rotation step.
  logic [COUNT_WIDTH-1:0] counts [MAX_PROCS];

  generate
    for (genvar k = 0; k < MAX_PROCS; k++) begin : g_cell
      vcu_cell #(
        .COUNT_WIDTH(COUNT_WIDTH),
        .INDEX      (k)
      ) u_cell (
        .clk        (clk),
        .rst        (rst),
        .cmd        (cmd),
        .elem_value (val_ext),
        .nbr_count  (counts[(k + 1) % MAX_PROCS]),
        .count      (counts[k])
      );
    end
  endgenerate

  // Output register.
  logic [VALUE_W-1:0]     head_value;
  logic [IDX_FIELD_W-1:0] out_index;
  logic [VALUE_W-1:0]     out_value;
  logic [PEER_W-1:0]      out_peer;

  generate
    if (COUNT_WIDTH >= VALUE_W) begin : g_out_wide
      assign head_value = counts[0][VALUE_W-1:0];
    end else begin : g_out_narrow
      assign head_value = VALUE_W'(counts[0]);
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_value <= head_value;
      out_index <= IDX_FIELD_W'(rot_cnt);
      out_peer  <= kind_peer;
      m_tuser   <= kind;
      m_tlast   <= PCOUNT_W'(rot_cnt) == n_used - PCOUNT_W'(1);
    end
  end

  assign m_tdata = {{(TDATA_W - PEER_W - IDX_FIELD_W - VALUE_W){1'b0}},
                    out_value, out_index, out_peer};

  // Checks.
  a_index_in_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> PCOUNT_W'(out_index) < n_used)
    else $error("emitted entry index beyond entries in use");

  a_last_on_final: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tlast) |-> PCOUNT_W'(out_index) == n_used - PCOUNT_W'(1))
    else $error("last marker not on final entry");

  a_event_emits: assert property (@(posedge clk) disable iff (rst)
    (accept && completes) |=> (state == ST_EMIT && rot_cnt == '0))
    else $error("completed event did not start emission");

  a_ring_aligned: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> (rot_cnt == '0))
    else $error("ring left unaligned when idle");

endmodule

// ===== tb/tb_vector_clock_unit.sv =====
`timescale 1ns / 1ps

module tb_vector_clock_unit;
  import vcu_pkg::*;

  localparam int MAX_PROCS     = 16;
  localparam int COUNT_WIDTH   = 32;
  localparam int SETTLE_CYCLES = 2 * MAX_PROCS + 8;
  localparam int CYCLE_LIMIT   = 300000;

  localparam logic [VALUE_W-1:0] CNT_MAX     = {VALUE_W{1'b1}};
  localparam logic [MODE_W-1:0]  MODE_UNUSED = 2'd3;

  localparam logic [PADDR_W-1:0] ADDR_OWN   = PADDR_W'({REG_OWN, 2'b00});
  localparam logic [PADDR_W-1:0] ADDR_COUNT = PADDR_W'({REG_COUNT, 2'b00});

  typedef struct packed {
    logic [MODE_W-1:0]      mode;
    logic [PEER_W-1:0]      peer;
    logic [IDX_FIELD_W-1:0] elem_index;
    logic [VALUE_W-1:0]     elem_value;
    logic                   elem_last;
  } event_beat_t;

  typedef struct packed {
    logic [MODE_W-1:0]      kind;
    logic [PEER_W-1:0]      peer;
    logic [IDX_FIELD_W-1:0] index;
    logic [VALUE_W-1:0]     value;
    logic                   last;
  } clock_entry_t;

  class clock_vector_tracker;
    logic [VALUE_W-1:0]     counters [MAX_PROCS];
    logic [IDX_FIELD_W-1:0] own_idx;
    logic [PCOUNT_W-1:0]    proc_count;
    clock_entry_t           due_entries [$];
    int unsigned            errors;

    function new();
      foreach (counters[k]) counters[k] = '0;
      own_idx    = OWN_RESET;
      proc_count = COUNT_RESET;
      errors     = 0;
    endfunction

    function int unsigned entries_in_use();
      if (proc_count == 0) return 1;
      if (proc_count > MAX_PROCS) return MAX_PROCS;
      return proc_count;
    endfunction

    function void take_config(logic [PADDR_W-1:0] addr, logic [PDATA_W-1:0] value);
      if (addr[2] == REG_OWN) own_idx = value[IDX_FIELD_W-1:0];
      else proc_count = value[PCOUNT_W-1:0];
    endfunction

    function void bump_own(int unsigned n);
      if (own_idx < n && counters[own_idx] != CNT_MAX) counters[own_idx] = counters[own_idx] + 1'b1;
    endfunction

    function void push_vector(int unsigned n, logic [MODE_W-1:0] kind, logic [PEER_W-1:0] peer);
      clock_entry_t e;
      for (int unsigned k = 0; k < n; k++) begin
        e.kind  = kind;
        e.peer  = peer;
        e.index = IDX_FIELD_W'(k);
        e.value = counters[k];
        e.last  = (k + 1 == n);
        due_entries.push_back(e);
      end
    endfunction

    function void take_event(event_beat_t b);
      int unsigned n;
      n = entries_in_use();
      case (b.mode)
        MODE_EXEC: begin
          bump_own(n);
          push_vector(n, MODE_EXEC, '0);
        end
        MODE_SEND: begin
          bump_own(n);
          push_vector(n, MODE_SEND, b.peer);
        end
        MODE_RECV: begin
          if (b.elem_index < n && b.elem_value > counters[b.elem_index])
            counters[b.elem_index] = b.elem_value;
          if (b.elem_last) begin
            bump_own(n);
            push_vector(n, MODE_RECV, b.peer);
          end
        end
        default: ;
      endcase
    endfunction

    function void compare_field(string name, logic [VALUE_W-1:0] want, logic [VALUE_W-1:0] got);
      if (want !== got) begin
        errors++;
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      end
    endfunction

    function void match_entry(logic [TDATA_W-1:0] tdata, logic [MODE_W-1:0] tuser, logic tlast);
      clock_entry_t e;
      if (due_entries.size() == 0) begin
        errors++;
        $display("%0t: unexpected beat, expected none, actual tdata %0h tuser %0h tlast %0b",
                 $time, tdata, tuser, tlast);
        return;
      end
      e = due_entries.pop_front();
      compare_field("event_kind", VALUE_W'(e.kind), VALUE_W'(tuser));
      compare_field("peer_out", VALUE_W'(e.peer), VALUE_W'(tdata[5:0]));
      compare_field("entry_index", VALUE_W'(e.index), VALUE_W'(tdata[11:6]));
      compare_field("entry_value", e.value, tdata[43:12]);
      compare_field("last_entry", VALUE_W'(e.last), VALUE_W'(tlast));
    endfunction
  endclass

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_tvalid;
  logic                   s_tready;
  // [5:0] peer, [11:6] elem_index, [43:12] elem_value, [47:44] zero
  logic [TDATA_W-1:0]     s_tdata;
  // [1:0] mode
  logic [MODE_W-1:0]      s_tuser;
  logic                   s_tlast;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  // [5:0] peer_out, [11:6] entry_index, [43:12] entry_value, [47:44] zero
  logic [TDATA_W-1:0]     m_tdata;
  // [1:0] event_kind
  logic [MODE_W-1:0]      m_tuser;
  logic                   m_tlast;
  logic                   psel;
  logic                   penable;
  logic                   pwrite;
  logic [PADDR_W-1:0]     paddr;
  logic [PDATA_W-1:0]     pwdata;
  logic [PDATA_W-1:0]     prdata;
  logic                   pready;

  clock_vector_tracker tracker;
  int                  send_idle_pct  = 0;
  int                  recv_stall_pct = 0;
  int unsigned         cycle_count    = 0;

  vector_clock_unit #(
    .MAX_PROCS   (MAX_PROCS),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) tracker.match_entry(m_tdata, m_tuser, m_tlast);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic send_fields(logic [MODE_W-1:0] mode, logic [PEER_W-1:0] peer,
                             logic [IDX_FIELD_W-1:0] idx, logic [VALUE_W-1:0] value,
                             logic last);
    event_beat_t b;
    b = '{mode: mode, peer: peer, elem_index: idx, elem_value: value, elem_last: last};
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {4'b0, value, idx, peer};
    s_tuser  <= mode;
    s_tlast  <= last;
    do @(posedge clk); while (!s_tready);
    tracker.take_event(b);
  endtask

  // Waits until every expected entry has arrived, then lets the ring finish its turn.
  task automatic drain();
    s_tvalid <= 1'b0;
    while (tracker.due_entries.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Leaves the bus selected after the access; the caller releases it.
  task automatic write_reg(logic [PADDR_W-1:0] addr, logic [PDATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    tracker.take_config(addr, value);
  endtask

  // Upper bits of the write data are random; the block keeps only the field bits.
  task automatic configure(logic [IDX_FIELD_W-1:0] own, logic [PCOUNT_W-1:0] count);
    write_reg(ADDR_OWN, (PDATA_W'($urandom) & ~PDATA_W'(6'h3F)) | PDATA_W'(own));
    write_reg(ADDR_COUNT, (PDATA_W'($urandom) & ~PDATA_W'(7'h7F)) | PDATA_W'(count));
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  function automatic logic [VALUE_W-1:0] pick_value(logic [IDX_FIELD_W-1:0] idx);
    logic [VALUE_W-1:0] base;
    base = (idx < MAX_PROCS) ? tracker.counters[idx] : VALUE_W'($urandom);
    case ($urandom_range(7))
      0: return '0;
      1: return CNT_MAX;
      2: return VALUE_W'($urandom);
      default: return base + VALUE_W'($urandom_range(4)) - VALUE_W'(2);
    endcase
  endfunction

  task automatic run_random(int count);
    int                     sent;
    int unsigned            n;
    int unsigned            len;
    int unsigned            pick;
    logic [PEER_W-1:0]      peer;
    logic [IDX_FIELD_W-1:0] idx;
    logic                   last;
    sent = 0;
    while (sent < count) begin
      pick = $urandom_range(99);
      n = tracker.entries_in_use();
      if (pick < 45) begin
        // A whole received vector, now and then cut short or with a stray index.
        len  = ($urandom_range(3) == 0) ? $urandom_range(1, n) : n;
        peer = PEER_W'($urandom);
        for (int unsigned k = 0; k < len; k++) begin
          idx = ($urandom_range(15) == 0) ? IDX_FIELD_W'($urandom) : IDX_FIELD_W'(k);
          send_fields(MODE_RECV, peer, idx, pick_value(idx), k + 1 == len);
        end
        sent += len;
      end else if (pick < 65) begin
        send_fields(MODE_EXEC, PEER_W'($urandom), IDX_FIELD_W'($urandom), $urandom,
                    1'($urandom));
        sent++;
      end else if (pick < 82) begin
        send_fields(MODE_SEND, PEER_W'($urandom), IDX_FIELD_W'($urandom), $urandom,
                    1'($urandom));
        sent++;
      end else if (pick < 90) begin
        send_fields(MODE_UNUSED, PEER_W'($urandom), IDX_FIELD_W'($urandom), $urandom,
                    1'($urandom));
      end else begin
        idx  = IDX_FIELD_W'($urandom);
        last = 1'($urandom);
        send_fields(MODE_RECV, PEER_W'($urandom), idx, pick_value(idx), last);
        if (last || idx < n) sent++;
      end
    end
  endtask

  initial begin
    logic [PCOUNT_W-1:0]    count;
    logic [IDX_FIELD_W-1:0] own;
    int unsigned            eff;

    tracker  = new();
    s_tvalid <= 1'b0;
    s_tdata  <= '0;
    s_tuser  <= '0;
    s_tlast  <= 1'b0;
    psel     <= 1'b0;
    penable  <= 1'b0;
    pwrite   <= 1'b0;
    paddr    <= '0;
    pwdata   <= '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset settings: own entry 0, sixteen entries in use.
    send_fields(MODE_EXEC, 6'h2A, 6'h15, 32'hA5A5A5A5, 1'b1);
    send_fields(MODE_SEND, 6'h3F, 6'h3F, 32'hFFFFFFFF, 1'b0);
    send_fields(MODE_RECV, 6'h00, 6'd0, 32'h00000000, 1'b0);
    send_fields(MODE_RECV, 6'h3F, 6'd15, 32'hFFFFFFFF, 1'b0);
    // An element beyond the vector is dropped, but its last marker still ends the event.
    send_fields(MODE_RECV, 6'h3F, 6'h3F, 32'h0000007B, 1'b1);
    send_fields(MODE_UNUSED, 6'h3F, 6'h3F, 32'hFFFFFFFF, 1'b1);
    send_fields(MODE_RECV, 6'h15, 6'd0, 32'hFFFFFFFE, 1'b1);
    // The own counter now sits at its maximum and must stay there.
    send_fields(MODE_EXEC, 6'h00, 6'h00, 32'h00000000, 1'b0);
    send_fields(MODE_SEND, 6'h00, 6'h2A, 32'h5A5A5A5A, 1'b1);

    // Own index out of range, entry count of zero clamped to one.
    drain();
    configure(6'd63, 7'd0);
    send_fields(MODE_EXEC, 6'h15, 6'h00, 32'h0, 1'b0);
    send_fields(MODE_SEND, 6'h2A, 6'h00, 32'h0, 1'b0);
    send_fields(MODE_RECV, 6'h01, 6'd0, 32'h00000005, 1'b1);
    send_fields(MODE_RECV, 6'h02, 6'd1, 32'h00000009, 1'b1);

    // Oversized count clamped to the full vector.
    drain();
    configure(6'd15, 7'd127);
    send_fields(MODE_EXEC, 6'h00, 6'h00, 32'h0, 1'b0);
    send_fields(MODE_RECV, 6'h07, 6'd15, 32'hFFFFFFFF, 1'b1);
    send_fields(MODE_EXEC, 6'h00, 6'h00, 32'h0, 1'b0);

    drain();
    configure(6'd16, 7'd17);
    send_fields(MODE_EXEC, 6'h00, 6'h00, 32'h0, 1'b0);
    send_fields(MODE_SEND, 6'h33, 6'h00, 32'h0, 1'b0);

    drain();
    configure(6'd0, 7'd1);
    send_fields(MODE_EXEC, 6'h00, 6'h00, 32'h0, 1'b0);

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct  = 16;
          recv_stall_pct = 67;
        end
        1: begin
          send_idle_pct  = 67;
          recv_stall_pct = 16;
        end
        default: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
      endcase
      for (int blk = 0; blk < 4; blk++) begin
        case ($urandom_range(5))
          0: count = 7'd1;
          1: count = 7'd16;
          2: count = 7'd0;
          3: count = 7'd127;
          default: count = PCOUNT_W'($urandom_range(2, 15));
        endcase
        eff = (count == 0) ? 1 : ((count > MAX_PROCS) ? MAX_PROCS : count);
        own = ($urandom_range(4) == 0) ? IDX_FIELD_W'($urandom)
                                       : IDX_FIELD_W'($urandom_range(0, eff - 1));
        drain();
        configure(own, count);
        run_random(25);
      end
    end

    drain();
    if (tracker.errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/vcu_pkg.sv
hw/rtl/vcu_cell.sv
hw/rtl/vector_clock_unit.sv
tb/tb_vector_clock_unit.sv
